// File: design/i2cm_pkg.sv
// i2cm_pkg: shared types, codes and constants of the I2C register access master.
// No dependencies; the design files other than i2cm_if refer to it by scoped names.
package i2cm_pkg;

  localparam int unsigned RecoveryPulses = 9;
  localparam logic [4:0]  RecoveryLimit  = 5'(RecoveryPulses);

  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;
  localparam logic [9:0]  TicksReset  = 10'd45;
  localparam logic [0:0]  RegTicksPerSlot = 1'b0;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StAddrNack  = 3'd1;
  localparam logic [2:0] StRegNack   = 3'd2;
  localparam logic [2:0] StDataNack  = 3'd3;
  localparam logic [2:0] StZeroLen   = 3'd4;

  typedef enum logic [1:0] {
    OpTick    = 2'd0,
    OpWrite   = 2'd1,
    OpRead    = 2'd2,
    OpRecover = 2'd3
  } opcode_e;

  typedef enum logic [24:0] {
    PhIdle   = 25'h0000001,
    PhStart0 = 25'h0000002,
    PhStart1 = 25'h0000004,
    PhStart2 = 25'h0000008,
    PhStart3 = 25'h0000010,
    PhWbit0  = 25'h0000020,
    PhWbit1  = 25'h0000040,
    PhWbit2  = 25'h0000080,
    PhWack0  = 25'h0000100,
    PhWack1  = 25'h0000200,
    PhWack2  = 25'h0000400,
    PhWack3  = 25'h0000800,
    PhRbit0  = 25'h0001000,
    PhRbit1  = 25'h0002000,
    PhRack0  = 25'h0004000,
    PhRack1  = 25'h0008000,
    PhRack2  = 25'h0010000,
    PhRack3  = 25'h0020000,
    PhStop0  = 25'h0040000,
    PhStop1  = 25'h0080000,
    PhStop2  = 25'h0100000,
    PhStop3  = 25'h0200000,
    PhRhead  = 25'h0400000,
    PhPulse0 = 25'h0800000,
    PhPulse1 = 25'h1000000
  } phase_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  device_address;
    logic [7:0]  register_address;
    logic [7:0]  write_value;
    logic [15:0] read_count;
    logic        sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       last_byte;
    logic       done_res;
    logic [2:0] status;
  } res_t;

endpackage

// File: design/i2cm_if.sv
// i2cm_if: valid/ready channel interfaces for requests and results.
// Refers to no other file; its field widths match those of i2cm_pkg.
interface i2cm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [6:0]  device_address;
  logic [7:0]  register_address;
  logic [7:0]  write_value;
  logic [15:0] read_count;
  logic        sda_in;

  modport source (output valid, opcode, device_address, register_address, write_value,
                  read_count, sda_in, input ready);
  modport sink (input valid, opcode, device_address, register_address, write_value,
                read_count, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_data;
  logic       last_byte;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, scl_out, sda_out, busy_res, read_valid, read_data,
                  last_byte, done_res, status, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, read_valid, read_data,
                last_byte, done_res, status, output ready);
endinterface

// File: design/i2cm_apb_regs.sv
// i2cm_apb_regs: APB register file holding ticks_per_slot.
// Depends on i2cm_pkg.
module i2cm_apb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [i2cm_pkg::ApbAddrW-1:0]   paddr,
  input  logic [i2cm_pkg::ApbDataW-1:0]   pwdata,
  output logic [i2cm_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  output logic [9:0]                      ticks_o
);

  logic [9:0] ticks_q, ticks_d;
  logic       hit;

  assign hit    = (paddr[i2cm_pkg::ApbAddrW-1:2] == i2cm_pkg::RegTicksPerSlot);
  assign pready = 1'b1;
  assign prdata = hit ? {{(i2cm_pkg::ApbDataW-10){1'b0}}, ticks_q} : '0;

  always_comb begin
    ticks_d = ticks_q;
    if (psel && penable && pwrite && hit) begin
      ticks_d = pwdata[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= i2cm_pkg::TicksReset;
    end else begin
      ticks_q <= ticks_d;
    end
  end

  assign ticks_o = ticks_q;

endmodule

// File: design/i2cm_engine.sv
// i2cm_engine: bus sequencer state and its one-slot-per-request next-state logic.
// Depends on i2cm_pkg; produces one result per accepted request.
module i2cm_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  i2cm_pkg::req_t   req_i,
  input  logic [9:0]       ticks_i,
  output i2cm_pkg::res_t   res_o
);

  i2cm_pkg::phase_e phase_q, phase_d, tgt;
  logic [9:0]  slot_q, slot_d, slot_inc, tps;
  logic [3:0]  bc_q, bc_d, bc_inc;
  logic [7:0]  shift_q, shift_d, rx_byte;
  logic [15:0] left_q, left_d;
  logic [6:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d, val_q, val_d;
  logic        scl_q, scl_d, sda_q, sda_d;
  logic [2:0]  fstat_q, fstat_d;
  logic        do_enter, idle;
  logic        ev_valid, ev_last, ev_done;
  logic [7:0]  ev_data;
  logic [2:0]  ev_status;
  i2cm_pkg::opcode_e op;

  assign op       = i2cm_pkg::opcode_e'(req_i.opcode);
  assign idle     = (phase_q == i2cm_pkg::PhIdle);
  assign tps      = (ticks_i == 10'd0) ? 10'd1 : ticks_i;
  assign slot_inc = slot_q + 10'd1;
  assign bc_inc   = bc_q + 4'd1;
  assign rx_byte  = {shift_q[6:0], req_i.sda_in};

  always_comb begin
    phase_d   = phase_q;
    slot_d    = slot_q;
    bc_d      = bc_q;
    shift_d   = shift_q;
    left_d    = left_q;
    dev_d     = dev_q;
    reg_d     = reg_q;
    val_d     = val_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    fstat_d   = fstat_q;
    tgt       = phase_q;
    do_enter  = 1'b0;
    ev_valid  = 1'b0;
    ev_last   = 1'b0;
    ev_done   = 1'b0;
    ev_data   = 8'd0;
    ev_status = i2cm_pkg::StOk;

    if (op == i2cm_pkg::OpTick) begin
      if (!idle) begin
        slot_d = slot_inc;
        if (slot_inc >= tps) begin
          // slot over: run the end-of-slot step of the current phase
          unique case (phase_q)
            i2cm_pkg::PhStart0: begin do_enter = 1'b1; tgt = i2cm_pkg::PhStart1; end
            i2cm_pkg::PhStart1: begin do_enter = 1'b1; tgt = i2cm_pkg::PhStart2; end
            i2cm_pkg::PhStart2: begin do_enter = 1'b1; tgt = i2cm_pkg::PhStart3; end
            i2cm_pkg::PhStart3: begin
              // first START sends the write address, a repeated START the read address
              if (fstat_q == i2cm_pkg::StOk) begin
                fstat_d = i2cm_pkg::StAddrNack;
                shift_d = {dev_q, 1'b0};
              end else begin
                fstat_d = i2cm_pkg::StDataNack;
                shift_d = {dev_q, 1'b1};
              end
              bc_d = 4'd0; do_enter = 1'b1; tgt = i2cm_pkg::PhWbit0;
            end
            i2cm_pkg::PhWbit0: begin do_enter = 1'b1; tgt = i2cm_pkg::PhWbit1; end
            i2cm_pkg::PhWbit1: begin do_enter = 1'b1; tgt = i2cm_pkg::PhWbit2; end
            i2cm_pkg::PhWbit2: begin
              shift_d  = {shift_q[6:0], 1'b0};
              bc_d     = bc_inc;
              do_enter = 1'b1;
              tgt      = (bc_inc >= 4'd8) ? i2cm_pkg::PhWack0 : i2cm_pkg::PhWbit0;
            end
            i2cm_pkg::PhWack0: begin do_enter = 1'b1; tgt = i2cm_pkg::PhWack1; end
            i2cm_pkg::PhWack1: begin do_enter = 1'b1; tgt = i2cm_pkg::PhWack2; end
            i2cm_pkg::PhWack2: begin
              // hold the acknowledge bit in the shifter until the next slot ends
              shift_d = {7'd0, req_i.sda_in};
              do_enter = 1'b1; tgt = i2cm_pkg::PhWack3;
            end
            i2cm_pkg::PhWack3: begin
              do_enter = 1'b1;
              if (shift_q != 8'd0) begin
                tgt = i2cm_pkg::PhStop0;
              end else if (fstat_q == i2cm_pkg::StAddrNack) begin
                fstat_d = i2cm_pkg::StRegNack;
                shift_d = reg_q; bc_d = 4'd0; tgt = i2cm_pkg::PhWbit0;
              end else if (fstat_q == i2cm_pkg::StRegNack) begin
                if (left_q == 16'd0) begin
                  fstat_d = i2cm_pkg::StDataNack;
                  shift_d = val_q; bc_d = 4'd0; tgt = i2cm_pkg::PhWbit0;
                end else begin
                  tgt = i2cm_pkg::PhStart0;
                end
              end else begin
                fstat_d = i2cm_pkg::StOk;
                if (left_q == 16'd0) begin
                  tgt = i2cm_pkg::PhStop0;
                end else begin
                  shift_d = 8'd0; bc_d = 4'd0; tgt = i2cm_pkg::PhRbit0;
                end
              end
            end
            i2cm_pkg::PhRbit0: begin do_enter = 1'b1; tgt = i2cm_pkg::PhRbit1; end
            i2cm_pkg::PhRbit1: begin
              shift_d  = rx_byte;
              bc_d     = bc_inc;
              do_enter = 1'b1;
              if (bc_inc >= 4'd8) begin
                left_d   = left_q - 16'd1;
                ev_valid = 1'b1;
                ev_data  = rx_byte;
                ev_last  = (left_q == 16'd1);
                tgt      = i2cm_pkg::PhRack0;
              end else begin
                tgt = i2cm_pkg::PhRbit0;
              end
            end
            i2cm_pkg::PhRack0: begin do_enter = 1'b1; tgt = i2cm_pkg::PhRack1; end
            i2cm_pkg::PhRack1: begin do_enter = 1'b1; tgt = i2cm_pkg::PhRack2; end
            i2cm_pkg::PhRack2: begin do_enter = 1'b1; tgt = i2cm_pkg::PhRack3; end
            i2cm_pkg::PhRack3: begin
              sda_d    = 1'b1;
              do_enter = 1'b1;
              if (left_q == 16'd0) begin
                tgt = i2cm_pkg::PhStop0;
              end else begin
                shift_d = 8'd0; bc_d = 4'd0; tgt = i2cm_pkg::PhRbit0;
              end
            end
            i2cm_pkg::PhStop0: begin do_enter = 1'b1; tgt = i2cm_pkg::PhStop1; end
            i2cm_pkg::PhStop1: begin do_enter = 1'b1; tgt = i2cm_pkg::PhStop2; end
            i2cm_pkg::PhStop2: begin do_enter = 1'b1; tgt = i2cm_pkg::PhStop3; end
            i2cm_pkg::PhStop3: begin
              ev_done   = 1'b1;
              ev_status = fstat_q;
              phase_d   = i2cm_pkg::PhIdle;
              slot_d    = 10'd0;
            end
            i2cm_pkg::PhRhead: begin
              bc_d = 4'd0; do_enter = 1'b1; tgt = i2cm_pkg::PhPulse0;
            end
            i2cm_pkg::PhPulse0: begin do_enter = 1'b1; tgt = i2cm_pkg::PhPulse1; end
            i2cm_pkg::PhPulse1: begin
              do_enter = 1'b1;
              if ({1'b0, bc_q} + 5'd1 >= i2cm_pkg::RecoveryLimit) begin
                tgt = i2cm_pkg::PhStop0;
              end else begin
                bc_d = bc_inc; tgt = i2cm_pkg::PhPulse0;
              end
            end
            default: begin
              phase_d = i2cm_pkg::PhIdle;
              slot_d  = 10'd0;
            end
          endcase
        end
      end
    end else if (idle) begin
      dev_d   = req_i.device_address;
      reg_d   = req_i.register_address;
      val_d   = req_i.write_value;
      fstat_d = i2cm_pkg::StOk;
      bc_d    = 4'd0;
      shift_d = 8'd0;
      left_d  = 16'd0;
      unique case (op)
        i2cm_pkg::OpWrite: begin
          do_enter = 1'b1; tgt = i2cm_pkg::PhStart0;
        end
        i2cm_pkg::OpRead: begin
          left_d = req_i.read_count;
          if (req_i.read_count == 16'd0) begin
            fstat_d   = i2cm_pkg::StZeroLen;
            ev_done   = 1'b1;
            ev_status = i2cm_pkg::StZeroLen;
          end else begin
            do_enter = 1'b1; tgt = i2cm_pkg::PhStart0;
          end
        end
        i2cm_pkg::OpRecover: begin
          do_enter = 1'b1; tgt = i2cm_pkg::PhRhead;
        end
        default: ;
      endcase
    end

    // pin change made on entry to the new slot
    if (do_enter) begin
      phase_d = tgt;
      slot_d  = 10'd0;
      unique case (tgt)
        i2cm_pkg::PhStart0, i2cm_pkg::PhWack1, i2cm_pkg::PhStop3: sda_d = 1'b1;
        i2cm_pkg::PhStart2, i2cm_pkg::PhStop1: sda_d = 1'b0;
        i2cm_pkg::PhStart1, i2cm_pkg::PhWbit2, i2cm_pkg::PhWack2, i2cm_pkg::PhRbit1,
        i2cm_pkg::PhRack2, i2cm_pkg::PhStop2, i2cm_pkg::PhPulse1: scl_d = 1'b1;
        i2cm_pkg::PhStart3, i2cm_pkg::PhWbit0, i2cm_pkg::PhWack0, i2cm_pkg::PhWack3,
        i2cm_pkg::PhRack0, i2cm_pkg::PhRack3, i2cm_pkg::PhStop0,
        i2cm_pkg::PhPulse0: scl_d = 1'b0;
        i2cm_pkg::PhWbit1: sda_d = shift_d[7];
        i2cm_pkg::PhRbit0: begin scl_d = 1'b0; sda_d = 1'b1; end
        i2cm_pkg::PhRack1: sda_d = (left_d == 16'd0);
        i2cm_pkg::PhRhead: begin scl_d = 1'b1; sda_d = 1'b1; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cm_pkg::PhIdle;
      slot_q  <= 10'd0;
      bc_q    <= 4'd0;
      shift_q <= 8'd0;
      left_q  <= 16'd0;
      dev_q   <= 7'd0;
      reg_q   <= 8'd0;
      val_q   <= 8'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      fstat_q <= i2cm_pkg::StOk;
    end else if (push_i) begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      bc_q    <= bc_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      val_q   <= val_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      fstat_q <= fstat_d;
    end
  end

  always_comb begin
    res_o.scl_out    = scl_d;
    res_o.sda_out    = sda_d;
    res_o.busy_res   = (phase_d != i2cm_pkg::PhIdle);
    res_o.read_valid = ev_valid;
    res_o.read_data  = ev_data;
    res_o.last_byte  = ev_valid & ev_last;
    res_o.done_res   = ev_done;
    res_o.status     = ev_status;
  end

`ifndef NO_ASSERTIONS
  a_rx_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && res_o.read_valid |-> !res_o.done_res && res_o.busy_res)
    else $error("received byte reported together with end of transfer");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && res_o.done_res |-> !res_o.busy_res)
    else $error("transfer ended but sequencer still busy");
  a_hold_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i |=> $stable(phase_q))
    else $error("phase moved without a request");
`endif

endmodule

// File: design/i2cm_out_buf.sv
// i2cm_out_buf: result register plus one skid entry for the result channel.
// Depends on i2cm_pkg and the i2cm_res_if interface.
module i2cm_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2cm_pkg::res_t  res_i,
  output logic            space_o,
  i2cm_res_if.source      res_o
);

  logic           out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  i2cm_pkg::res_t out_q, out_d, skid_q, skid_d;
  logic           pop, out_free;

  assign pop      = out_valid_q & res_o.ready;
  assign out_free = ~out_valid_q | pop;
  assign space_o  = ~skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      // result stalled: park the new one
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.scl_out    = out_q.scl_out;
  assign res_o.sda_out    = out_q.sda_out;
  assign res_o.busy_res   = out_q.busy_res;
  assign res_o.read_valid = out_q.read_valid;
  assign res_o.read_data  = out_q.read_data;
  assign res_o.last_byte  = out_q.last_byte;
  assign res_o.done_res   = out_q.done_res;
  assign res_o.status     = out_q.status;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty result register");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed into a full buffer");
  a_park_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready && push_i |=> skid_valid_q)
    else $error("stalled push was not parked");
`endif

endmodule

// File: design/i2c_master_register_access.sv
// i2c_master_register_access: top level of the I2C register access master.
// Depends on i2cm_pkg, i2cm_if, i2cm_apb_regs, i2cm_engine and i2cm_out_buf.
//
//   port     dir   handshake            carries
//   req_i    in    valid/ready          opcode, addresses, value, count, sda_in
//   res_o    out   valid/ready          pins, busy, read byte, done, status
//   APB      in    psel/penable/pready  ticks_per_slot at address 0
//
// One request per cycle while req_i is ready; results go to the result register, via
// the skid entry while res_o is stalled. The sequencer takes at most one slot step per
// request, so one state register set and the result register bound the path; a skid
// entry keeps req_i ready for one more request while a result is stalled.
// After reset the bus pins are released, the sequencer is idle and ticks_per_slot is 45.
module i2c_master_register_access (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cm_pkg::ApbAddrW-1:0] paddr,
  input  logic [i2cm_pkg::ApbDataW-1:0] pwdata,
  output logic [i2cm_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  i2cm_req_if.sink                      req_i,
  i2cm_res_if.source                    res_o
);

  logic           push, space;
  logic [9:0]     ticks;
  i2cm_pkg::req_t req;
  i2cm_pkg::res_t res;

  assign req_i.ready = space;
  assign push        = req_i.valid & space;

  assign req.opcode           = req_i.opcode;
  assign req.device_address   = req_i.device_address;
  assign req.register_address = req_i.register_address;
  assign req.write_value      = req_i.write_value;
  assign req.read_count       = req_i.read_count;
  assign req.sda_in           = req_i.sda_in;

  i2cm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ticks_o (ticks)
  );

  i2cm_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (req),
    .ticks_i (ticks),
    .res_o   (res)
  );

  i2cm_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .space_o (space),
    .res_o   (res_o)
  );

endmodule
